// File: rtl/swtp_pkg.sv
// ----------------------------------------------------------------------------
// swtp_pkg
// Shared types and constants for the switched total-power accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package swtp_pkg;

	// default sizing
	localparam int MAX_CHAN_DEF       = 128;
	localparam int MAX_TP_INPUTS_DEF  = 16;
	localparam int BUFS_PER_STATE_DEF = 3;
	localparam int NUM_STATES_DEF     = 3;

	// field widths
	localparam int ACC_W    = 32;
	localparam int SAMPLE_W = 8;
	localparam int TIME_W   = 13;
	localparam int CHAN_W   = 7;
	localparam int SLOT_W   = 4;
	localparam int DST_W    = 2;
	localparam int PWR_W    = 8;

	// configuration registers
	localparam int EDGE_W    = 13;
	localparam int TPB_W     = 14;
	localparam int SKY_W     = 2;
	localparam int CFG_W     = 14;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_EDGE_SAMPLES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMES_PER_BUFFER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SKY_STATE        = 2'd2;

	localparam logic [EDGE_W-1:0] EDGE_RST = '0;
	localparam logic [TPB_W-1:0]  TPB_RST  = 14'd8192;
	localparam logic [SKY_W-1:0]  SKY_RST  = '0;

	// item function codes
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_DRAIN  = 1'b1;

	// one beat as it leaves the front end
	typedef struct packed {
		logic                       drain;     // read-and-clear item
		logic                       hit;       // entry in range
		logic                       tp;        // total-power sample
		logic [PWR_W-1:0]           pwr;       // (re*re+im*im)>>8 after blanking
		logic signed [SAMPLE_W-1:0] out_real;
		logic signed [SAMPLE_W-1:0] out_imag;
		logic                       done;      // end of switching cycle
	} beat_t;

endpackage

`default_nettype wire

// File: rtl/swtp_ram.sv
// ----------------------------------------------------------------------------
// swtp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swtp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/swtp_sched.sv
// ----------------------------------------------------------------------------
// swtp_sched
// Front end: configuration registers, buffer/state counters, edge blanking,
// sample power and accumulator address for the accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module swtp_sched import swtp_pkg::*; #(
	parameter int MAX_CHAN       = MAX_CHAN_DEF,
	parameter int MAX_TP_INPUTS  = MAX_TP_INPUTS_DEF,
	parameter int BUFS_PER_STATE = BUFS_PER_STATE_DEF,
	parameter int NUM_STATES     = NUM_STATES_DEF,
	localparam int ACC_DEPTH = NUM_STATES * MAX_CHAN * MAX_TP_INPUTS,
	localparam int AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data,
	input  wire logic                       accept,
	input  wire logic                       func,
	input  wire logic signed [SAMPLE_W-1:0] sample_real,
	input  wire logic signed [SAMPLE_W-1:0] sample_imag,
	input  wire logic [TIME_W-1:0]          time_index,
	input  wire logic [CHAN_W-1:0]          channel,
	input  wire logic [SLOT_W-1:0]          tp_slot,
	input  wire logic                       is_tp,
	input  wire logic                       last_of_buffer,
	input  wire logic [DST_W-1:0]           drain_state,
	output beat_t                           beat,
	output logic [AW-1:0]                   addr
);

	localparam int BW = (BUFS_PER_STATE > 1) ? $clog2(BUFS_PER_STATE) : 1;
	localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam logic [BW-1:0] BUF_LAST = BW'(BUFS_PER_STATE - 1);
	localparam logic [SW-1:0] ST_LAST  = SW'(NUM_STATES - 1);

	logic [EDGE_W-1:0] edge_q;
	logic [TPB_W-1:0]  tpb_q;
	logic [SKY_W-1:0]  sky_q;
	logic [BW-1:0]     buf_q;
	logic [SW-1:0]     st_q;

	logic                       blank;
	logic                       off_sky;
	logic                       chan_ok;
	logic                       slot_ok;
	logic                       dst_ok;
	logic [TPB_W:0]             t_end;
	logic signed [SAMPLE_W-1:0] re_b;
	logic signed [SAMPLE_W-1:0] im_b;
	logic signed [2*SAMPLE_W-1:0] sq_re;
	logic signed [2*SAMPLE_W-1:0] sq_im;
	logic [2*SAMPLE_W-1:0]      pwr_sum;
	logic [31:0]                st_sel;
	logic [31:0]                addr_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= EDGE_RST;
			tpb_q  <= TPB_RST;
			sky_q  <= SKY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EDGE_SAMPLES:     edge_q <= cfg_data[EDGE_W-1:0];
				REG_TIMES_PER_BUFFER: tpb_q  <= cfg_data[TPB_W-1:0];
				REG_SKY_STATE:        sky_q  <= cfg_data[SKY_W-1:0];
				default: ;
			endcase
		end
	end

	// advance buffer and switch state on the last accepted sample beat of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			st_q  <= '0;
		end else if (accept && func == FUNC_SAMPLE && last_of_buffer) begin
			if (buf_q == BUF_LAST) begin
				buf_q <= '0;
				st_q  <= (st_q == ST_LAST) ? '0 : st_q + 1'b1;
			end else begin
				buf_q <= buf_q + 1'b1;
			end
		end
	end

	always_comb begin
		t_end = {2'b00, time_index} + {2'b00, edge_q};
		blank = 1'b0;
		if (buf_q == '0)
			blank = time_index < edge_q;
		else if (buf_q == BUF_LAST)
			blank = t_end >= {1'b0, tpb_q};

		off_sky = 32'(st_q) != 32'(sky_q);
		chan_ok = 32'(channel) < 32'(MAX_CHAN);
		slot_ok = 32'(tp_slot) < 32'(MAX_TP_INPUTS);
		dst_ok  = 32'(drain_state) < 32'(NUM_STATES);

		re_b    = blank ? '0 : sample_real;
		im_b    = blank ? '0 : sample_imag;
		sq_re   = re_b * re_b;
		sq_im   = im_b * im_b;
		pwr_sum = {1'b0, sq_re[2*SAMPLE_W-2:0]} + {1'b0, sq_im[2*SAMPLE_W-2:0]};

		st_sel    = (func == FUNC_DRAIN) ? 32'(drain_state) : 32'(st_q);
		addr_full = (st_sel * 32'(MAX_CHAN) + 32'(channel)) * 32'(MAX_TP_INPUTS)
			+ 32'(tp_slot);
		addr      = addr_full[AW-1:0];

		beat.drain = func == FUNC_DRAIN;
		beat.hit   = chan_ok && slot_ok && (func == FUNC_SAMPLE || dst_ok);
		beat.tp    = func == FUNC_SAMPLE && is_tp;
		beat.pwr   = pwr_sum[2*SAMPLE_W-1:SAMPLE_W];
		if (func == FUNC_DRAIN) begin
			beat.out_real = '0;
			beat.out_imag = '0;
		end else if (is_tp && (blank || off_sky)) begin
			beat.out_real = '0;
			beat.out_imag = '0;
		end else begin
			beat.out_real = sample_real;
			beat.out_imag = sample_imag;
		end
		beat.done = func == FUNC_SAMPLE && last_of_buffer && st_q == ST_LAST
			&& buf_q == BUF_LAST;
	end

endmodule

`default_nettype wire

// File: rtl/swtp_acc.sv
// ----------------------------------------------------------------------------
// swtp_acc
// Accumulator store: clearing pass after reset, read-modify-write stage with
// forwarding of the previous write, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swtp_acc import swtp_pkg::*; #(
	parameter int MAX_CHAN       = MAX_CHAN_DEF,
	parameter int MAX_TP_INPUTS  = MAX_TP_INPUTS_DEF,
	parameter int NUM_STATES     = NUM_STATES_DEF,
	localparam int ACC_DEPTH = NUM_STATES * MAX_CHAN * MAX_TP_INPUTS,
	localparam int AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire beat_t                 beat,
	input  wire logic [AW-1:0]         addr,
	output logic                       busy,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [SAMPLE_W-1:0] out_real,
	output logic signed [SAMPLE_W-1:0] out_imag,
	output logic [ACC_W-1:0]           accum_value,
	output logic                       cycle_done
);

	logic          clearing_q;
	logic [AW-1:0] clr_q;

	logic          s1_valid_q;
	logic          s1_new_q;
	beat_t         beat_s1;
	logic [AW-1:0] addr_s1;

	logic             wr_en_q;
	logic [AW-1:0]    wr_addr_q;
	logic [ACC_W-1:0] wr_data_q;
	logic [ACC_W-1:0] held_q;

	logic             out_valid_q;

	logic             s1_adv;
	logic [ACC_W-1:0] rdata;
	logic [ACC_W-1:0] old_val;
	logic [ACC_W:0]   sum;
	logic [ACC_W-1:0] new_val;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [ACC_W-1:0] ram_wdata;

	swtp_ram #(
		.WIDTH (ACC_W),
		.DEPTH (ACC_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (addr),
		.rdata (rdata)
	);

	assign s1_adv = !out_valid_q || !out_stall;
	assign busy   = clearing_q || (s1_valid_q && !s1_adv);

	always_comb begin
		// the registered previous write was not yet visible at the RAM read
		if (!s1_new_q)
			old_val = held_q;
		else if (wr_en_q && wr_addr_q == addr_s1)
			old_val = wr_data_q;
		else
			old_val = rdata;

		sum     = {1'b0, old_val} + {{(ACC_W+1-PWR_W){1'b0}}, beat_s1.pwr};
		new_val = beat_s1.drain ? '0 : (sum[ACC_W] ? '1 : sum[ACC_W-1:0]);

		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = s1_valid_q && s1_adv && beat_s1.hit
				&& (beat_s1.drain || beat_s1.tp);
			ram_waddr = addr_s1;
			ram_wdata = new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(ACC_DEPTH - 1))
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s1_new_q    <= 1'b0;
			wr_en_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_new_q <= accept;
			wr_en_q  <= ram_we;
			if (accept)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;
			if (s1_valid_q && s1_adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= ram_waddr;
		wr_data_q <= ram_wdata;
		held_q    <= old_val;
		if (accept) begin
			beat_s1 <= beat;
			addr_s1 <= addr;
		end
		if (s1_valid_q && s1_adv) begin
			out_real    <= beat_s1.out_real;
			out_imag    <= beat_s1.out_imag;
			accum_value <= (beat_s1.drain && beat_s1.hit) ? old_val : '0;
			cycle_done  <= beat_s1.done;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/switched_total_power_accumulator.sv
// An accepted beat is registered into the read-modify-write stage, then the
// output register. Throughput: one beat per cycle while in_stall is low; the
// RAM is read at accept and written from that stage, previous write forwarded.
// Reset: counters and registers clear at once, then a clearing pass zeroes
// the NUM_STATES*MAX_CHAN*MAX_TP_INPUTS entry RAM (6144 entries by default)
// with in_stall held high; configuration writes are taken during the pass.
// ----------------------------------------------------------------------------
// switched_total_power_accumulator
// Blanks switch-state edges, accumulates sample power per state, channel and
// slot, and drains accumulators by read-and-clear beats.
// ----------------------------------------------------------------------------
`default_nettype none

module switched_total_power_accumulator import swtp_pkg::*; #(
	parameter int MAX_CHAN       = MAX_CHAN_DEF,
	parameter int MAX_TP_INPUTS  = MAX_TP_INPUTS_DEF,
	parameter int BUFS_PER_STATE = BUFS_PER_STATE_DEF,
	parameter int NUM_STATES     = NUM_STATES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_W-1:0]           cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       func,
	input  wire logic signed [SAMPLE_W-1:0] sample_real,
	input  wire logic signed [SAMPLE_W-1:0] sample_imag,
	input  wire logic [TIME_W-1:0]          time_index,
	input  wire logic [CHAN_W-1:0]          channel,
	input  wire logic [SLOT_W-1:0]          tp_slot,
	input  wire logic                       is_tp,
	input  wire logic                       last_of_buffer,
	input  wire logic [DST_W-1:0]           drain_state,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [SAMPLE_W-1:0]      out_real,
	output logic signed [SAMPLE_W-1:0]      out_imag,
	output logic [ACC_W-1:0]                accum_value,
	output logic                            cycle_done
);

	localparam int ACC_DEPTH = NUM_STATES * MAX_CHAN * MAX_TP_INPUTS;
	localparam int AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

	logic          accept;
	logic          busy;
	beat_t         beat;
	logic [AW-1:0] addr;

	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	swtp_sched #(
		.MAX_CHAN       (MAX_CHAN),
		.MAX_TP_INPUTS  (MAX_TP_INPUTS),
		.BUFS_PER_STATE (BUFS_PER_STATE),
		.NUM_STATES     (NUM_STATES)
	) u_sched (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accept         (accept),
		.func           (func),
		.sample_real    (sample_real),
		.sample_imag    (sample_imag),
		.time_index     (time_index),
		.channel        (channel),
		.tp_slot        (tp_slot),
		.is_tp          (is_tp),
		.last_of_buffer (last_of_buffer),
		.drain_state    (drain_state),
		.beat           (beat),
		.addr           (addr)
	);

	swtp_acc #(
		.MAX_CHAN      (MAX_CHAN),
		.MAX_TP_INPUTS (MAX_TP_INPUTS),
		.NUM_STATES    (NUM_STATES)
	) u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.beat        (beat),
		.addr        (addr),
		.busy        (busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_real    (out_real),
		.out_imag    (out_imag),
		.accum_value (accum_value),
		.cycle_done  (cycle_done)
	);

endmodule

`default_nettype wire

// File: rtl/swtp_checker.sv
// ----------------------------------------------------------------------------
// swtp_checker
// Port-level checks for the switched total-power accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module swtp_checker import swtp_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_stall,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic signed [SAMPLE_W-1:0] out_real,
	input wire logic signed [SAMPLE_W-1:0] out_imag,
	input wire logic [ACC_W-1:0]           accum_value,
	input wire logic                       cycle_done
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(accum_value)
			&& $stable(out_real) && $stable(out_imag) && $stable(cycle_done))
		else $error("stalled result beat changed");

	// a nonzero drained value comes with zero sample fields and no cycle_done
	a_drain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accum_value != '0 |-> out_real == '0 && out_imag == '0
			&& !cycle_done)
		else $error("drain beat carries sample data");

	// the clearing pass holds off input right after reset
	a_clear_stall: assert property (@(posedge clk)
		!arst_n ##1 arst_n |-> in_stall)
		else $error("input taken before the accumulator clear");

endmodule

bind switched_total_power_accumulator swtp_checker u_swtp_checker (.*);

`default_nettype wire
